### rtl/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

   // Field widths of the command stream and the pixel words
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned DATA_W  = 14;
   localparam int unsigned COL_W   = 15;
   localparam int unsigned ROW_W   = 14;
   localparam int unsigned CSR_IDX_W = 1;

   // Decoder phase
   typedef enum logic [1:0] {
      PH_LOW   = 2'd0,
      PH_HIGH  = 2'd1,
      PH_RUN   = 2'd2,
      PH_ENDED = 2'd3
   } phase_type;

   // Command opcodes (low two bits of the command word)
   typedef enum logic [1:0] {
      OP_COL = 2'd0,
      OP_RUN = 2'd1,
      OP_ROW = 2'd2,
      OP_END = 2'd3
   } opcode_type;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 1'd1;

   // One result word
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [BYTE_W-1:0] pixel;
      logic              outside;
      logic              stream_end;
   } rsp_type;

   // Parser to output buffer
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

endpackage

### rtl/scd_in_reg.sv
`timescale 1ns / 1ps

module scd_in_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [scd_pkg::BYTE_W-1:0]   req_stream_byte,
   input  logic                         req_stream_start,
   input  logic                         take,
   output logic                         held_valid,
   output logic [scd_pkg::BYTE_W-1:0]   held_byte,
   output logic                         held_start
);

   logic                       valid_ff, valid_in;
   logic [scd_pkg::BYTE_W-1:0] byte_ff;
   logic                       start_ff;
   logic                       load;

   // Free, or being emptied this cycle
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= req_stream_byte;
         start_ff <= req_stream_start;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_start = start_ff;

endmodule

### rtl/scd_parser.sv
`timescale 1ns / 1ps

module scd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [scd_pkg::BYTE_W-1:0]   stream_byte,
   input  logic                         stream_start,
   input  logic [scd_pkg::DATA_W-1:0]   sprite_width,
   input  logic [scd_pkg::DATA_W-1:0]   sprite_height,
   output scd_pkg::res_type             res
);

   scd_pkg::phase_type         phase_ff, phase_in, phase_eff;
   logic [scd_pkg::BYTE_W-1:0] hold_ff, hold_in, hold_eff;
   logic [scd_pkg::COL_W-1:0]  col_ff, col_in, col_eff;
   logic [scd_pkg::ROW_W-1:0]  row_ff, row_in, row_eff;
   logic [scd_pkg::DATA_W-1:0] run_ff, run_in, run_eff;

   logic [2*scd_pkg::BYTE_W-1:0] word;
   scd_pkg::opcode_type          op;
   logic [scd_pkg::DATA_W-1:0]   data;
   logic                         last_pixel;

   // A start mark clears the position and phase before the word is used
   always_comb begin
      phase_eff = stream_start ? scd_pkg::PH_LOW : phase_ff;
      hold_eff  = stream_start ? '0 : hold_ff;
      col_eff   = stream_start ? '0 : col_ff;
      row_eff   = stream_start ? '0 : row_ff;
      run_eff   = stream_start ? '0 : run_ff;
   end

   assign word       = {stream_byte, hold_eff};
   assign op         = scd_pkg::opcode_type'(word[1:0]);
   assign data       = word[2*scd_pkg::BYTE_W-1:2];
   assign last_pixel = (run_eff == scd_pkg::DATA_W'(1));

   // Next phase
   always_comb begin
      phase_in = phase_eff;
      case (phase_eff)
         scd_pkg::PH_LOW: begin
            phase_in = scd_pkg::PH_HIGH;
         end
         scd_pkg::PH_HIGH: begin
            case (op)
               scd_pkg::OP_RUN: phase_in = (data == '0) ? scd_pkg::PH_LOW : scd_pkg::PH_RUN;
               scd_pkg::OP_END: phase_in = scd_pkg::PH_ENDED;
               default:         phase_in = scd_pkg::PH_LOW;
            endcase
         end
         scd_pkg::PH_RUN: begin
            phase_in = last_pixel ? scd_pkg::PH_LOW : scd_pkg::PH_RUN;
         end
         default: begin
            phase_in = scd_pkg::PH_ENDED;
         end
      endcase
   end

   // Position, run count and the result word
   always_comb begin
      hold_in = hold_eff;
      col_in  = col_eff;
      row_in  = row_eff;
      run_in  = run_eff;
      res     = '0;
      case (phase_eff)
         scd_pkg::PH_LOW: begin
            hold_in = stream_byte;
         end
         scd_pkg::PH_HIGH: begin
            case (op)
               scd_pkg::OP_COL: col_in = scd_pkg::COL_W'(data);
               scd_pkg::OP_ROW: row_in = data;
               scd_pkg::OP_RUN: begin
                  if (data == '0) col_in = '0;
                  else            run_in = data;
               end
               default: begin
                  res.valid           = 1'b1;
                  res.data.stream_end = 1'b1;
               end
            endcase
         end
         scd_pkg::PH_RUN: begin
            res.valid        = 1'b1;
            res.data.col     = col_eff;
            res.data.row     = row_eff;
            res.data.pixel   = stream_byte;
            res.data.outside = (col_eff >= scd_pkg::COL_W'(sprite_width))
                               || (row_eff >= sprite_height);
            run_in           = run_eff - scd_pkg::DATA_W'(1);
            col_in           = last_pixel ? '0 : col_eff + scd_pkg::COL_W'(1);
         end
         default: begin
         end
      endcase
      if (!en) res.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= scd_pkg::PH_LOW;
         hold_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         run_ff   <= '0;
      end else if (en) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         run_ff   <= run_in;
      end
   end

endmodule

### rtl/scd_out_buf.sv
`timescale 1ns / 1ps

module scd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  scd_pkg::res_type  push,
   output logic              can_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scd_pkg::rsp_type  rsp_data
);

   logic             out_valid_ff, out_valid_in;
   scd_pkg::rsp_type out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   scd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign pop      = out_valid_ff && rsp_ready;
   assign can_take = !skid_valid_ff;

   // Output register with a skid word behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push.valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = push.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### rtl/sprite_command_stream_decoder_top.sv
`timescale 1ns / 1ps

// Sprite command stream decoder.
// req_ channel: one stream byte per word, with a start mark on the first byte
// of a sprite. Byte pairs form command words (low byte first) that set the
// column, set the row, open a pixel run or end the sprite.
// rsp_ channel: one word per pixel of a run (column, row, palette index and
// an outside flag against the canvas size), and one word with stream_end set
// for the end command; command bytes themselves give no word.
// csr_ channel: index 0 writes sprite_width, index 1 writes sprite_height;
// always ready; the user must see that they are written only while the
// stream is idle, as the block does not enforce it. An accepted byte is
// held in the input register, then goes through the parser into the output
// register that drives rsp_valid; an occupied skid word keeps it in the input
// register. Throughput: one byte per cycle while the skid word is free.
// Reset clears the phase, the position, the run count and both canvas sizes,
// and empties the input and output registers.
// When the receiver stalls, the output register and one skid word absorb
// results; req_ready drops only once the skid word is occupied.

module sprite_command_stream_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [scd_pkg::BYTE_W-1:0]        req_stream_byte,
   input  logic                              req_stream_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [scd_pkg::COL_W-1:0]         rsp_col,
   output logic [scd_pkg::ROW_W-1:0]         rsp_row,
   output logic [scd_pkg::BYTE_W-1:0]        rsp_pixel,
   output logic                              rsp_outside,
   output logic                              rsp_stream_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [scd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scd_pkg::DATA_W-1:0]        csr_wdata
);

   logic [scd_pkg::DATA_W-1:0] width_ff, height_ff;
   logic                       held_valid;
   logic [scd_pkg::BYTE_W-1:0] held_byte;
   logic                       held_start;
   logic                       can_take;
   logic                       advance;
   scd_pkg::res_type           res;
   scd_pkg::rsp_type           rsp_data;

   // Canvas size registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            scd_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            scd_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A held byte moves on whenever the skid word is free
   assign advance = held_valid && can_take;

   scd_in_reg u_in_reg (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .req_stream_start (req_stream_start),
      .take             (advance),
      .held_valid       (held_valid),
      .held_byte        (held_byte),
      .held_start       (held_start)
   );

   scd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .stream_byte   (held_byte),
      .stream_start  (held_start),
      .sprite_width  (width_ff),
      .sprite_height (height_ff),
      .res           (res)
   );

   scd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_col        = rsp_data.col;
   assign rsp_row        = rsp_data.row;
   assign rsp_pixel      = rsp_data.pixel;
   assign rsp_outside    = rsp_data.outside;
   assign rsp_stream_end = rsp_data.stream_end;

endmodule

### test/sprite_command_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module sprite_command_stream_decoder_top_tb;

   // One byte of the command stream as offered on the req_ channel
   typedef struct packed {
      logic [scd_pkg::BYTE_W-1:0] value;
      logic                       start;
   } stream_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [scd_pkg::BYTE_W-1:0]    req_stream_byte = '0;
   logic                          req_stream_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [scd_pkg::COL_W-1:0]     rsp_col;
   logic [scd_pkg::ROW_W-1:0]     rsp_row;
   logic [scd_pkg::BYTE_W-1:0]    rsp_pixel;
   logic                          rsp_outside;
   logic                          rsp_stream_end;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [scd_pkg::CSR_IDX_W-1:0] csr_index = scd_pkg::REG_WIDTH;
   logic [scd_pkg::DATA_W-1:0]    csr_wdata = '0;

   sprite_command_stream_decoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_col          (rsp_col),
      .rsp_row          (rsp_row),
      .rsp_pixel        (rsp_pixel),
      .rsp_outside      (rsp_outside),
      .rsp_stream_end   (rsp_stream_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder copy kept by the testbench
   scd_pkg::phase_type         dec_phase = scd_pkg::PH_LOW;
   logic [scd_pkg::BYTE_W-1:0] low_hold = '0;
   logic [scd_pkg::COL_W-1:0]  cur_col = '0;
   logic [scd_pkg::ROW_W-1:0]  cur_row = '0;
   logic [scd_pkg::DATA_W-1:0] run_left = '0;
   logic [scd_pkg::DATA_W-1:0] canvas_width = '0;
   logic [scd_pkg::DATA_W-1:0] canvas_height = '0;

   stream_item_type  stream_queue[$];
   scd_pkg::rsp_type expected_words[$];
   stream_item_type  next_item;
   scd_pkg::rsp_type want;

   int unsigned mismatch_count = 0;
   int unsigned stim_count = 0;
   int unsigned tx_gap = 0;
   int unsigned rx_gap = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int unsigned long_stall_req = 0;
   int unsigned long_stall_seen = 0;
   int unsigned long_stall_left = 0;

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Works out what one accepted byte does and queues the word it yields
   task automatic decode_byte(input logic [scd_pkg::BYTE_W-1:0] b, input logic start);
      logic [15:0]                cmd;
      logic [scd_pkg::DATA_W-1:0] data;
      scd_pkg::rsp_type           pix;
      pix = '0;
      if (start) begin
         dec_phase = scd_pkg::PH_LOW;
         low_hold  = '0;
         cur_col   = '0;
         cur_row   = '0;
         run_left  = '0;
      end
      case (dec_phase)
         scd_pkg::PH_LOW: begin
            low_hold  = b;
            dec_phase = scd_pkg::PH_HIGH;
         end
         scd_pkg::PH_HIGH: begin
            cmd       = {b, low_hold};
            data      = cmd[15:2];
            dec_phase = scd_pkg::PH_LOW;
            case (cmd[1:0])
               scd_pkg::OP_COL: cur_col = {1'b0, data};
               scd_pkg::OP_ROW: cur_row = data;
               scd_pkg::OP_RUN: begin
                  // empty run just rewinds the column
                  if (data == '0) begin
                     cur_col = '0;
                  end else begin
                     run_left  = data;
                     dec_phase = scd_pkg::PH_RUN;
                  end
               end
               default: begin
                  dec_phase      = scd_pkg::PH_ENDED;
                  pix.stream_end = 1'b1;
                  expected_words.push_back(pix);
               end
            endcase
         end
         scd_pkg::PH_RUN: begin
            pix.col     = cur_col;
            pix.row     = cur_row;
            pix.pixel   = b;
            pix.outside = (cur_col >= {1'b0, canvas_width}) || (cur_row >= canvas_height);
            expected_words.push_back(pix);
            run_left = run_left - 1'b1;
            if (run_left == '0) begin
               cur_col   = '0;
               dec_phase = scd_pkg::PH_LOW;
            end else begin
               cur_col = cur_col + 1'b1;
            end
         end
         default: ; // ended: bytes ignored until a start mark
      endcase
   endtask

   // Driver: offers queued bytes, predicts on every accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_stream_byte, req_stream_start);
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (stream_queue.size() != 0) begin
               next_item = stream_queue.pop_front();
               req_stream_byte  <= next_item.value;
               req_stream_start <= next_item.start;
               req_valid        <= 1'b1;
               tx_gap = pick_gap(tx_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks result words in order, drives rsp_ready with stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: col=%0d row=%0d pixel=%0d outside=%0d end=%0d",
                      rsp_col, rsp_row, rsp_pixel, rsp_outside, rsp_stream_end);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_col !== want.col) begin
                  $error("col: expected %0d, actual %0d", want.col, rsp_col);
                  mismatch_count++;
               end
               if (rsp_row !== want.row) begin
                  $error("row: expected %0d, actual %0d", want.row, rsp_row);
                  mismatch_count++;
               end
               if (rsp_pixel !== want.pixel) begin
                  $error("pixel: expected %0d, actual %0d", want.pixel, rsp_pixel);
                  mismatch_count++;
               end
               if (rsp_outside !== want.outside) begin
                  $error("outside: expected %0d, actual %0d", want.outside, rsp_outside);
                  mismatch_count++;
               end
               if (rsp_stream_end !== want.stream_end) begin
                  $error("stream_end: expected %0d, actual %0d", want.stream_end,
                         rsp_stream_end);
                  mismatch_count++;
               end
            end
            rx_gap = pick_gap(rx_quiet);
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_ready <= 1'b0;
         end else if (long_stall_req != long_stall_seen) begin
            // long hold-off so the output buffer fills and req_ready drops
            long_stall_seen = long_stall_req;
            long_stall_left = 300;
            rsp_ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stream building helpers
   task automatic add_byte(input logic [scd_pkg::BYTE_W-1:0] b, input logic start);
      stream_item_type it;
      it.value = b;
      it.start = start;
      stream_queue.push_back(it);
      stim_count++;
   endtask

   task automatic add_cmd(input scd_pkg::opcode_type op,
                          input logic [scd_pkg::DATA_W-1:0] data, input logic start);
      add_byte({data[5:0], op}, start);
      add_byte(data[13:6], 1'b0);
   endtask

   task automatic add_run(input logic [scd_pkg::DATA_W-1:0] len, input logic start);
      add_cmd(scd_pkg::OP_RUN, len, start);
      repeat (len) add_byte(scd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
   endtask

   // Trailing byte that is not counted as a command byte
   task automatic add_tail_byte();
      stream_item_type it;
      it.value = scd_pkg::BYTE_W'($urandom_range(0, 255));
      it.start = 1'b0;
      stream_queue.push_back(it);
   endtask

   // Positions cluster near zero and around the canvas edge
   function automatic logic [scd_pkg::DATA_W-1:0] pick_pos(
         input logic [scd_pkg::DATA_W-1:0] edge_at);
      int unsigned r, lo, hi;
      r  = $urandom_range(0, 99);
      lo = (edge_at > 2) ? edge_at - 2 : 0;
      hi = (edge_at + 2 > 16383) ? 16383 : edge_at + 2;
      if (r < 60) return scd_pkg::DATA_W'($urandom_range(0, 40));
      if (r < 85) return scd_pkg::DATA_W'($urandom_range(lo, hi));
      if (r < 95) return scd_pkg::DATA_W'($urandom_range(0, 16383));
      return 14'h3FFF;
   endfunction

   function automatic logic [scd_pkg::DATA_W-1:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return scd_pkg::DATA_W'($urandom_range(1, 6));
      if (r < 95) return scd_pkg::DATA_W'($urandom_range(7, 30));
      return scd_pkg::DATA_W'($urandom_range(31, 120));
   endfunction

   // One sprite: start mark, a few commands, then an end or a broken tail
   task automatic add_sprite();
      int unsigned n_cmds, k, r, len, cnt;
      logic first;
      first  = 1'b1;
      n_cmds = $urandom_range(1, 6);
      for (k = 0; k < n_cmds; k++) begin
         r = $urandom_range(0, 99);
         if (r < 25) add_cmd(scd_pkg::OP_COL, pick_pos(canvas_width), first);
         else if (r < 45) add_cmd(scd_pkg::OP_ROW, pick_pos(canvas_height), first);
         else if (r < 95) add_run(pick_len(), first);
         else add_cmd(scd_pkg::OP_RUN, '0, first);
         first = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
         add_cmd(scd_pkg::OP_END, scd_pkg::DATA_W'($urandom_range(0, 16383)), 1'b0);
         // trailing bytes after the end are ignored by the block
         cnt = $urandom_range(0, 3);
         repeat (cnt) add_tail_byte();
      end else if (r < 92) begin
         // run cut short by the next start mark
         len = pick_len() + 1;
         add_cmd(scd_pkg::OP_RUN, scd_pkg::DATA_W'(len), 1'b0);
         cnt = $urandom_range(0, len - 1);
         repeat (cnt) add_byte(scd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else if (r < 96) begin
         add_byte(scd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else begin
         cnt = $urandom_range(4, 20);
         repeat (cnt) add_byte(scd_pkg::BYTE_W'($urandom_range(0, 255)),
                               $urandom_range(0, 9) == 0);
      end
   endtask

   task automatic write_reg(input logic [scd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [scd_pkg::DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         scd_pkg::REG_WIDTH:  canvas_width  = val;
         scd_pkg::REG_HEIGHT: canvas_height = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Sender idle and every expected word in, plus the pipeline latency
   task automatic wait_drained();
      do @(negedge clock);
      while (stream_queue.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int unsigned ph;
      logic [scd_pkg::DATA_W-1:0] w, h;
      stream_item_type tail;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extreme position, column past 14 bits, empty run, bytes after end
      add_cmd(scd_pkg::OP_COL, 14'h3FFF, 1'b1);
      add_cmd(scd_pkg::OP_ROW, 14'h3FFF, 1'b0);
      add_cmd(scd_pkg::OP_RUN, 14'd3, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hA5, 1'b0);
      add_cmd(scd_pkg::OP_RUN, '0, 1'b0);
      add_cmd(scd_pkg::OP_END, 14'h3FFF, 1'b0);
      tail.value = 8'hFF;
      tail.start = 1'b0;
      stream_queue.push_back(tail);
      wait_drained();

      write_reg(scd_pkg::REG_WIDTH, 14'd4);
      write_reg(scd_pkg::REG_HEIGHT, 14'd2);
      @(negedge clock);
      // Start mark in the middle of a word, then in the middle of a long run
      add_byte(8'h5A, 1'b1);
      add_cmd(scd_pkg::OP_COL, 14'd3, 1'b1);
      add_cmd(scd_pkg::OP_ROW, 14'd1, 1'b0);
      add_cmd(scd_pkg::OP_RUN, 14'h3FFF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'h7F, 1'b0);
      add_cmd(scd_pkg::OP_END, '0, 1'b1);
      wait_drained();

      // Random sprites under several canvas sizes
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin w = 14'h3FFF; h = 14'h3FFF; end
            2: begin w = 14'd1; h = 14'd1; end
            4: begin w = '0; h = 14'h3FFF; end
            default: begin
               w = scd_pkg::DATA_W'($urandom_range(0, 48));
               h = scd_pkg::DATA_W'($urandom_range(0, 48));
            end
         endcase
         write_reg(scd_pkg::REG_WIDTH, w);
         write_reg(scd_pkg::REG_HEIGHT, h);
         @(negedge clock);
         tx_quiet = (ph == 0 || ph == 3);
         rx_quiet = (ph == 5);
         stim_count = 0;
         while (stim_count < 325) add_sprite();
         if (ph == 3) long_stall_req <= long_stall_req + 1;
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: many times the slowest legal run
   initial begin
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
